@@ rtl/tmoc_pkg.sv @@
// Package for the TSO memory order checker: transaction structs, op and
// status codes, queue depth and the control structs between top and cells.
// Depends on nothing.
package tmoc_pkg;

  // Queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned AgeW       = 64;
  localparam int unsigned ScanW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  // Memory op codes
  localparam logic [2:0] OpLd    = 3'd0;
  localparam logic [2:0] OpSt    = 3'd1;
  localparam logic [2:0] OpLr    = 3'd2;
  localparam logic [2:0] OpSc    = 3'd3;
  localparam logic [2:0] OpFence = 3'd4;

  // Commands
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRemove = 1'b1;

  // Result status codes
  localparam logic [1:0] StCorrect = 2'd0;
  localparam logic [1:0] StNoMatch = 2'd1;
  localparam logic [1:0] StViolate = 2'd2;

  // Input transaction
  typedef struct packed {
    logic        command;
    logic [2:0]  op;
    logic [31:0] addr;
    logic [31:0] data;
    logic [31:0] req_id;
  } req_t;

  // Result transaction
  typedef struct packed {
    logic        accepted;
    logic [1:0]  status;
    logic        bypass_valid;
    logic [31:0] bypass_value;
  } rsp_t;

  // Forwarding candidate handed along the row of cells
  typedef struct packed {
    logic            valid;
    logic [AgeW-1:0] age;
    logic [31:0]     data;
  } cand_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic            check;   // load forwarding candidates, flag violations
    logic            scan;    // shift candidates one cell towards cell 0
    logic [AgeW-1:0] stamp;   // age written by an insert
    logic [AgeW-1:0] my_age;  // age of the entry being removed
    req_t            req;
  } cell_ctrl_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic            free;
    logic            match;
    logic            viol;
    logic [AgeW-1:0] age;
  } cell_stat_t;

endpackage

@@ rtl/tmoc_cell.sv @@
// One queue slot of the TSO memory order checker: holds a request, matches
// removes, compares ages and passes forwarding candidates to its neighbour.
// Depends on tmoc_pkg.
module tmoc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmoc_pkg::cell_ctrl_t ctrl_i,
  input  logic                write_i,
  input  logic                clear_i,
  input  tmoc_pkg::cand_t     nbr_i,
  output tmoc_pkg::cand_t     cand_o,
  output tmoc_pkg::cell_stat_t stat_o
);
  import tmoc_pkg::*;

  logic            valid_q;
  logic [AgeW-1:0] age_q;
  logic [2:0]      op_q;
  logic [31:0]     addr_q, data_q, id_q;
  cand_t           cand_q, cand_d;
  logic            key_hit, fields_hit, older, ld_past_st;

  // Slot valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (write_i) begin
      valid_q <= 1'b1;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    if (write_i) begin
      age_q  <= ctrl_i.stamp;
      op_q   <= ctrl_i.req.op;
      addr_q <= ctrl_i.req.addr;
      data_q <= ctrl_i.req.data;
      id_q   <= ctrl_i.req.req_id;
    end
  end

  // Match against a remove transaction
  always_comb begin
    key_hit = valid_q && (op_q == ctrl_i.req.op) && (id_q == ctrl_i.req.req_id);
    case (ctrl_i.req.op) inside
      OpFence:    fields_hit = 1'b1;
      OpLd, OpLr: fields_hit = (addr_q == ctrl_i.req.addr);
      OpSt, OpSc: fields_hit = (addr_q == ctrl_i.req.addr) && (data_q == ctrl_i.req.data);
      default:    fields_hit = 1'b0;
    endcase
  end

  // Ordering against the removed entry
  assign older      = valid_q && (age_q < ctrl_i.my_age);
  assign ld_past_st = (ctrl_i.req.op == OpLd) && (op_q == OpSt);

  assign stat_o.free  = !valid_q;
  assign stat_o.match = key_hit && fields_hit;
  assign stat_o.viol  = older && !ld_past_st;
  assign stat_o.age   = age_q;

  // Candidate: load own on check, then keep the younger of own and neighbour
  always_comb begin
    cand_d = cand_q;
    if (ctrl_i.check) begin
      cand_d.valid = older && ld_past_st && (addr_q == ctrl_i.req.addr);
      cand_d.age   = age_q;
      cand_d.data  = data_q;
    end else if (ctrl_i.scan) begin
      if (nbr_i.valid && (!cand_q.valid || (nbr_i.age > cand_q.age))) begin
        cand_d = nbr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
  end

  assign cand_o = cand_q;

endmodule

@@ rtl/tso_memory_order_checker.sv @@
// Top level of the TSO memory order checker: sequencer, age counter and the
// row of slot cells. Depends on tmoc_pkg and tmoc_cell.
//
// A transaction is taken when start_i is high and busy_o low; busy_o stays
// high until the result has been produced, and the result appears on rsp_o
// for one cycle with rsp_valid_o, in the cycle in which busy_o drops. The
// receiver cannot stall. An insert, and a remove that finds no match, end in
// state SLook; a remove of anything but a plain load ends in SCheck, after
// SLook; a plain load that passes the ordering check goes on from SCheck to
// SScan for the youngest-older-store search, in which forwarding candidates
// move one cell per cycle along the row of slots towards slot 0.
module tso_memory_order_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tmoc_pkg::req_t req_i,
  output logic           busy_o,
  output logic           rsp_valid_o,
  output tmoc_pkg::rsp_t rsp_o
);
  import tmoc_pkg::*;

  typedef enum logic [3:0] {
    SIdle  = 4'b0001,
    SLook  = 4'b0010,
    SCheck = 4'b0100,
    SScan  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  req_t            req_q;
  logic [AgeW-1:0] age_ctr_q, age_ctr_d;
  logic [AgeW-1:0] my_age_q, my_age_d;
  logic [ScanW-1:0] cnt_q, cnt_d;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  cell_ctrl_t      ctrl;
  cell_stat_t      stat [QueueDepth];
  cand_t           cand [QueueDepth+1];
  logic [QueueDepth-1:0] free_sel, match_sel, write_en, clear_en, viol_vec;
  logic            any_free, any_match, seen_free, seen_match;
  logic [AgeW-1:0] sel_age;

  // Lowest free and lowest matching slot
  always_comb begin
    seen_free  = 1'b0;
    seen_match = 1'b0;
    sel_age    = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      free_sel[i]  = stat[i].free && !seen_free;
      match_sel[i] = stat[i].match && !seen_match;
      seen_free    = seen_free || stat[i].free;
      seen_match   = seen_match || stat[i].match;
      viol_vec[i]  = stat[i].viol;
      if (match_sel[i]) begin
        sel_age = sel_age | stat[i].age;
      end
    end
    any_free  = seen_free;
    any_match = seen_match;
  end

  // Broadcast control
  always_comb begin
    ctrl.check  = (state_q == SCheck);
    ctrl.scan   = (state_q == SScan);
    ctrl.stamp  = age_ctr_q;
    ctrl.my_age = my_age_q;
    ctrl.req    = req_q;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    age_ctr_d   = age_ctr_q;
    my_age_d    = my_age_q;
    cnt_d       = cnt_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    write_en    = '0;
    clear_en    = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          state_d = SLook;
        end
      end
      SLook: begin
        rsp_d = '0;
        if (req_q.command == CmdInsert) begin
          rsp_d.accepted = any_free;
          rsp_valid_d    = 1'b1;
          state_d        = SIdle;
          if (any_free) begin
            write_en  = free_sel;
            age_ctr_d = age_ctr_q + AgeW'(1);
          end
        end else begin
          rsp_d.accepted = 1'b1;
          if (!any_match) begin
            rsp_d.status = StNoMatch;
            rsp_valid_d  = 1'b1;
            state_d      = SIdle;
          end else begin
            clear_en = match_sel;
            my_age_d = sel_age;
            state_d  = SCheck;
          end
        end
      end
      SCheck: begin
        if (|viol_vec) begin
          rsp_d.status = StViolate;
          rsp_valid_d  = 1'b1;
          state_d      = SIdle;
        end else if (req_q.op != OpLd) begin
          rsp_valid_d = 1'b1;
          state_d     = SIdle;
        end else begin
          cnt_d   = '0;
          state_d = SScan;
        end
      end
      SScan: begin
        if (cnt_q == ScanW'(QueueDepth - 1)) begin
          rsp_d.bypass_valid = cand[0].valid;
          rsp_d.bypass_value = cand[0].valid ? cand[0].data : '0;
          rsp_valid_d        = 1'b1;
          state_d            = SIdle;
        end else begin
          cnt_d = cnt_q + ScanW'(1);
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      age_ctr_q   <= AgeW'(1);
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      age_ctr_q   <= age_ctr_d;
      rsp_valid_q <= rsp_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == SIdle)) begin
      req_q <= req_i;
    end
    my_age_q <= my_age_d;
    rsp_q    <= rsp_d;
  end

  // Row of slot cells; the last one sees an empty neighbour
  assign cand[QueueDepth] = '0;

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    tmoc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .write_i (write_en[g]),
      .clear_i (clear_en[g]),
      .nbr_i   (cand[g+1]),
      .cand_o  (cand[g]),
      .stat_o  (stat[g])
    );
  end

  assign busy_o      = (state_q != SIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

@@ rtl/tmoc_checker.sv @@
// Port-level assertions for the TSO memory order checker, bound to the top.
// Depends on tmoc_pkg and tso_memory_order_checker.
module tmoc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           rsp_valid_o,
  input tmoc_pkg::rsp_t rsp_o
);
  import tmoc_pkg::*;

  // A taken transaction makes the block busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("transaction taken but block not busy");

  // A result only appears once the block has gone idle
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy_o && $past(busy_o))
    else $error("result outside end of a transaction");

  // Status is always a defined code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == StCorrect || rsp_o.status == StNoMatch ||
                     rsp_o.status == StViolate))
    else $error("undefined status");

  // Forwarding only on a correct, accepted remove
  a_bypass_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.bypass_valid |-> rsp_o.accepted && rsp_o.status == StCorrect)
    else $error("bypass on a failed transaction");

  // No forwarded value without bypass
  a_bypass_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.bypass_valid |-> rsp_o.bypass_value == '0)
    else $error("bypass value set without bypass");

endmodule

bind tso_memory_order_checker tmoc_checker u_tmoc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
